>>> sv/assert_macros.svh
// Assertion macros for the checker file of the terminal writer.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-edge implication, muted while reset is high.
`define TMW_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("tmw assertion failed");

// Next-edge implication, muted while reset is high.
`define TMW_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("tmw assertion failed");

// Next-edge implication, checked through reset as well.
`define TMW_ASSERT_NEXT_ALWAYS(label, clk, cond, prop) \
   label: assert property (@(posedge clk) (cond) |=> (prop)) \
      else $error("tmw assertion failed");

`endif

>>> sv/tmw_pkg.sv
// Shared constants, codes and types of the text-mode terminal writer.
// Depends on nothing; the design, checker and test files import it.
package tmw_pkg;

   // Screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int TAB_STOP   = 8;

   // Field and internal widths
   localparam int OP_W   = 2;
   localparam int CHAR_W = 8;
   localparam int IDX_W  = 11;
   localparam int POS_W  = 11;
   localparam int CELL_W = 16;
   localparam int ATTR_W = 8;
   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int COL_W  = $clog2(COLUMNS + TAB_STOP);
   localparam int ROW_W  = $clog2(ROWS + 1);
   localparam int CMP_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

   // Command queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Cell and register constants
   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_BACKSPACE   = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB         = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LINE_FEED   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN      = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_FIRST_PRINT = 8'h20;
   localparam logic [CHAR_W-1:0] CH_LAST_PRINT  = 8'h7F;

   typedef enum logic [OP_W-1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   // One classified item as the back carries it out
   typedef struct packed {
      logic              write_en;
      logic              scroll_en;
      logic              clear_en;
      logic              read_en;
      logic              in_range;
      logic [ADDR_W-1:0] write_pos;
      logic [CELL_W-1:0] write_data;
      logic [ADDR_W-1:0] read_pos;
      logic [POS_W-1:0]  cursor_position;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_INIT,
      BK_IDLE,
      BK_EXEC,
      BK_CLEAR,
      BK_SCROLL,
      BK_DONE
   } back_state_type;

endpackage

>>> sv/tmw_ifs.sv
// Request and response channel interfaces of the terminal writer.
// Depends on tmw_pkg for field widths.
interface tmw_req_if import tmw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [CHAR_W-1:0] char_code;
   logic [IDX_W-1:0]  cell_index;

   modport source (output valid, output operation, output char_code, output cell_index,
                   input ready);
   modport sink (input valid, input operation, input char_code, input cell_index,
                 output ready);
   modport monitor (input valid, input ready, input operation, input char_code,
                    input cell_index);
endinterface

interface tmw_rsp_if import tmw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  cursor_position;
   logic [CELL_W-1:0] cell_value;

   modport source (output valid, output cursor_position, output cell_value, input ready);
   modport sink (input valid, input cursor_position, input cell_value, output ready);
   modport monitor (input valid, input ready, input cursor_position, input cell_value);
endinterface

>>> sv/tmw_front.sv
// Front of the terminal writer: accepts request words, tracks the cursor and the
// attribute register, and turns each word into a command. Depends on tmw_pkg, tmw_ifs.
module tmw_front import tmw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   tmw_req_if.sink           req_bus,
   input  logic              csr_write_enable,
   input  logic [ATTR_W-1:0] csr_write_data,
   input  logic              queue_full,
   input  logic              back_busy,
   output logic              queue_push,
   output cmd_type           queue_cmd
);

   logic [COL_W-1:0]  col_ff, col_in, col_step;
   logic [ROW_W-1:0]  row_ff, row_in, row_step;
   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic              accept, printable, put_write, put_scroll;
   logic [CMP_W-1:0]  old_lin, new_lin, idx_ext;
   op_type            op;

   function automatic logic [CMP_W-1:0] linear_pos(logic [ROW_W-1:0] row,
                                                   logic [COL_W-1:0] col);
      linear_pos = CMP_W'(row) * CMP_W'(COLUMNS) + CMP_W'(col);
   endfunction

   // Take a word whenever the queue has room and the screen is initialized
   assign req_bus.ready = !queue_full && !back_busy;
   assign accept        = req_bus.valid && req_bus.ready;
   assign op            = op_type'(req_bus.operation);
   assign printable     = (req_bus.char_code >= CH_FIRST_PRINT) &&
                          (req_bus.char_code <= CH_LAST_PRINT);

   // Interpret a put byte, then wrap the column and detect scroll
   always_comb begin
      col_step   = col_ff;
      row_step   = row_ff;
      put_write  = 1'b0;
      put_scroll = 1'b0;
      case (req_bus.char_code)
         CH_BACKSPACE: begin
            if (col_ff != '0) col_step = col_ff - COL_W'(1);
         end
         CH_TAB: begin
            col_step = (col_ff + COL_W'(TAB_STOP)) & ~COL_W'(TAB_STOP - 1);
         end
         CH_RETURN: begin
            col_step = '0;
         end
         CH_LINE_FEED: begin
            col_step = '0;
            row_step = row_ff + ROW_W'(1);
         end
         default: begin
            if (printable) begin
               put_write = 1'b1;
               col_step  = col_ff + COL_W'(1);
            end
         end
      endcase
      if (col_step >= COL_W'(COLUMNS)) begin
         col_step = '0;
         row_step = row_step + ROW_W'(1);
      end
      if (row_step >= ROW_W'(ROWS)) begin
         put_scroll = 1'b1;
         row_step   = ROW_W'(ROWS - 1);
      end
   end

   // Advance the cursor on accepted words
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         case (op)
            OP_PUT: begin
               col_in = col_step;
               row_in = row_step;
            end
            OP_CLEAR: begin
               col_in = '0;
               row_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign attr_in = csr_write_enable ? csr_write_data : attr_ff;

   // Build the command for the back
   assign old_lin = linear_pos(row_ff, col_ff);
   assign new_lin = linear_pos(row_in, col_in);
   assign idx_ext = CMP_W'(req_bus.cell_index);

   always_comb begin
      queue_push                = accept;
      queue_cmd.write_en        = (op == OP_PUT) && put_write;
      queue_cmd.scroll_en       = (op == OP_PUT) && put_scroll;
      queue_cmd.clear_en        = (op == OP_CLEAR);
      queue_cmd.read_en         = (op == OP_READ);
      queue_cmd.in_range        = (idx_ext < CMP_W'(CELL_COUNT));
      queue_cmd.write_pos       = old_lin[ADDR_W-1:0];
      queue_cmd.write_data      = {attr_ff, req_bus.char_code};
      queue_cmd.read_pos        = idx_ext[ADDR_W-1:0];
      queue_cmd.cursor_position = new_lin[POS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         attr_ff <= ATTR_RESET;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         attr_ff <= attr_in;
      end
   end

endmodule

>>> sv/tmw_queue.sv
// Short command queue between front and back of the terminal writer.
// Depends on tmw_pkg for the command type and depth.
module tmw_queue import tmw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);

   cmd_type            entry_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full    = (count_ff == QCNT_W'(QDEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

>>> sv/tmw_back.sv
// Back of the terminal writer: owns the screen memory and its circular row offset,
// carries out commands and drives the response register. Depends on tmw_pkg, tmw_ifs.
module tmw_back import tmw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    queue_empty,
   input  cmd_type queue_cmd,
   output logic    queue_pop,
   output logic    init_busy,
   tmw_rsp_if.source rsp_bus
);

   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic [ADDR_W-1:0] top_ff, top_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [CELL_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic [CELL_W-1:0] rd_data_ff;
   logic [CELL_W-1:0] mem [CELL_COUNT];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [CELL_W-1:0] mem_wdata;
   logic              slot_free, last_cell, last_col;

   // Map a screen position to memory through the top-row offset
   function automatic logic [ADDR_W-1:0] to_phys(logic [ADDR_W-1:0] lpos,
                                                 logic [ADDR_W-1:0] top);
      logic [ADDR_W:0] sum;
      sum = {1'b0, lpos} + {1'b0, top};
      if (sum >= (ADDR_W + 1)'(CELL_COUNT)) sum = sum - (ADDR_W + 1)'(CELL_COUNT);
      to_phys = sum[ADDR_W-1:0];
   endfunction

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign last_cell = (sweep_ff == ADDR_W'(CELL_COUNT - 1));
   assign last_col  = (sweep_ff == ADDR_W'(COLUMNS - 1));
   assign init_busy = (state_ff == BK_INIT);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_INIT: begin
            if (last_cell) state_in = BK_IDLE;
         end
         BK_IDLE: begin
            if (!queue_empty && slot_free) state_in = BK_EXEC;
         end
         BK_EXEC: begin
            if (cmd_ff.clear_en) state_in = BK_CLEAR;
            else if (cmd_ff.scroll_en) state_in = BK_SCROLL;
            else state_in = BK_DONE;
         end
         BK_CLEAR: begin
            if (last_cell) state_in = BK_DONE;
         end
         BK_SCROLL: begin
            if (last_col) state_in = BK_DONE;
         end
         BK_DONE: begin
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Datapath and handshake outputs per state
   always_comb begin
      queue_pop    = 1'b0;
      cmd_in       = cmd_ff;
      sweep_in     = sweep_ff;
      top_in       = top_ff;
      mem_we       = 1'b0;
      mem_waddr    = sweep_ff;
      mem_wdata    = BLANK_CELL;
      mem_raddr    = to_phys(cmd_ff.read_pos, top_ff);
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_cell_in  = rsp_cell_ff;
      case (state_ff)
         BK_INIT, BK_CLEAR: begin
            // blank the whole screen, one cell a cycle
            mem_we   = 1'b1;
            sweep_in = sweep_ff + ADDR_W'(1);
            if (last_cell) begin
               sweep_in = '0;
               top_in   = '0;
            end
         end
         BK_IDLE: begin
            if (!queue_empty && slot_free) begin
               queue_pop = 1'b1;
               cmd_in    = queue_cmd;
            end
         end
         BK_EXEC: begin
            // store a printable character; a read is issued from mem_raddr
            mem_we    = cmd_ff.write_en;
            mem_waddr = to_phys(cmd_ff.write_pos, top_ff);
            mem_wdata = cmd_ff.write_data;
            sweep_in  = '0;
         end
         BK_SCROLL: begin
            // blank the old top row, then make the next row the top
            mem_we    = 1'b1;
            mem_waddr = top_ff + sweep_ff;
            sweep_in  = sweep_ff + ADDR_W'(1);
            if (last_col) begin
               sweep_in = '0;
               top_in   = (top_ff == ADDR_W'(CELL_COUNT - COLUMNS)) ? '0 :
                          top_ff + ADDR_W'(COLUMNS);
            end
         end
         BK_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_pos_in   = cmd_ff.cursor_position;
            rsp_cell_in  = (cmd_ff.read_en && cmd_ff.in_range) ? rd_data_ff : '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.cursor_position = rsp_pos_ff;
   assign rsp_bus.cell_value      = rsp_cell_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_INIT;
         sweep_ff     <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   // Screen memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[mem_raddr];
   end

endmodule

>>> sv/text_mode_terminal_writer.sv
// Channel   Direction  Carries
// req_bus   in         operation, char_code, cell_index
// rsp_bus   out        cursor_position, cell_value
// csr_*     in         attribute register write (write enable, data)
//
// A put, read or no-op passes through the back states idle, exec and done; a put
// that scrolls adds the scroll state and a clear the clear state, both paced by
// the single write port of the screen memory. The front runs ahead through a
// 4-entry command queue. After reset the back blanks the screen with req_bus.ready
// low. The response register takes a new word only once the previous one has
// been taken.
module text_mode_terminal_writer import tmw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   tmw_req_if.sink           req_bus,
   tmw_rsp_if.source         rsp_bus,
   input  logic              csr_write_enable,
   input  logic [ATTR_W-1:0] csr_write_data
);

   logic    queue_push, queue_pop, queue_full, queue_empty, back_busy;
   cmd_type front_cmd, back_cmd;

   tmw_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .back_busy        (back_busy),
      .queue_push       (queue_push),
      .queue_cmd        (front_cmd)
   );

   tmw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_cmd (front_cmd),
      .full     (queue_full),
      .pop      (queue_pop),
      .pop_cmd  (back_cmd),
      .empty    (queue_empty)
   );

   tmw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_cmd   (back_cmd),
      .queue_pop   (queue_pop),
      .init_busy   (back_busy),
      .rsp_bus     (rsp_bus)
   );

endmodule

>>> sv/tmw_checker.sv
// Port-level checks of the terminal writer, bound to the top level.
// Depends on tmw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tmw_checker import tmw_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [POS_W-1:0]  rsp_cursor_position,
   input logic [CELL_W-1:0] rsp_cell_value
);

   // Hold a stalled response word
   `TMW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_cursor_position) && $stable(rsp_cell_value))

   // Reset drops any pending response
   `TMW_ASSERT_NEXT_ALWAYS(a_reset_drops_rsp, clock, reset, !rsp_valid)

   // Screen initialization blocks requests right after reset
   `TMW_ASSERT_NEXT_ALWAYS(a_reset_blocks_req, clock, reset, !req_ready)

   // Cursor always lands on the screen
   `TMW_ASSERT_SAME(a_cursor_on_screen, clock, reset, rsp_valid, rsp_cursor_position < POS_W'(CELL_COUNT))

endmodule

bind text_mode_terminal_writer tmw_checker u_tmw_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_bus.ready),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_cursor_position (rsp_bus.cursor_position),
   .rsp_cell_value      (rsp_bus.cell_value)
);

>>> test/text_mode_terminal_writer_test.sv
// Self-checking bench for text_mode_terminal_writer: directed and random traffic
// against an in-bench screen and cursor model, under three handshake pacing settings.
// Depends on tmw_pkg and the channel interfaces in tmw_ifs.sv.
module text_mode_terminal_writer_test;
   import tmw_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int REPORT_LIMIT   = 10;
   localparam int HALF_PHASE     = 100;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_position;
      logic [CELL_W-1:0] cell_value;
   } reply_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_write_enable;
   logic [ATTR_W-1:0] csr_write_data;

   tmw_req_if req_bus ();
   tmw_rsp_if rsp_bus ();

   text_mode_terminal_writer dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Screen model and the replies it has produced but not yet seen
   logic [CELL_W-1:0] screen [CELL_COUNT];
   int                cursor_col;
   int                cursor_row;
   logic [ATTR_W-1:0] attr_reg;
   reply_type         due_replies [$];

   int mismatch_count;
   int reply_count;
   int accepted_count;
   int counted_items;
   int sent_words;
   int scroll_count;
   int clear_count;
   int read_count;
   int csr_writes;
   int stall_cycles;
   int send_idle_pct;
   int recv_idle_pct;

   // Apply one request word to the screen model and return the reply it causes
   function automatic reply_type advance_screen(op_type op, logic [CHAR_W-1:0] ch,
                                                logic [IDX_W-1:0] idx);
      reply_type r;
      r.cell_value = '0;
      case (op)
         OP_PUT: begin
            if (ch == CH_BACKSPACE) begin
               if (cursor_col != 0) cursor_col--;
            end else if (ch == CH_TAB) begin
               cursor_col = (cursor_col + TAB_STOP) & ~(TAB_STOP - 1);
            end else if (ch == CH_RETURN) begin
               cursor_col = 0;
            end else if (ch == CH_LINE_FEED) begin
               cursor_col = 0;
               cursor_row++;
            end else if (ch >= CH_FIRST_PRINT && ch <= CH_LAST_PRINT) begin
               screen[cursor_row * COLUMNS + cursor_col] = {attr_reg, ch};
               cursor_col++;
            end
            // Wrap at the right edge, then scroll past the bottom row
            if (cursor_col >= COLUMNS) begin
               cursor_col = 0;
               cursor_row++;
            end
            if (cursor_row >= ROWS) begin
               for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
               for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen[i] = BLANK_CELL;
               cursor_row = ROWS - 1;
               scroll_count++;
            end
         end
         OP_CLEAR: begin
            foreach (screen[i]) screen[i] = BLANK_CELL;
            cursor_col = 0;
            cursor_row = 0;
            clear_count++;
         end
         OP_READ: begin
            read_count++;
            if (idx < CELL_COUNT) r.cell_value = screen[idx];
         end
         default: ;
      endcase
      r.cursor_position = POS_W'(cursor_row * COLUMNS + cursor_col);
      return r;
   endfunction

   // Check each reply word, then predict for each accepted request word
   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      if (reset === 1'b0) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.cursor_position = rsp_bus.cursor_position;
            got.cell_value      = rsp_bus.cell_value;
            reply_count++;
            if (due_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected reply word %0d: cursor %0d cell %h",
                           reply_count, got.cursor_position, got.cell_value);
            end else begin
               want = due_replies.pop_front();
               if (got.cursor_position !== want.cursor_position ||
                   got.cell_value !== want.cell_value) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("reply %0d: cursor %0d expected %0d, cell %h expected %h",
                              reply_count, got.cursor_position, want.cursor_position,
                              got.cell_value, want.cell_value);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            accepted_count++;
            due_replies.push_back(advance_screen(op_type'(req_bus.operation),
                                                 req_bus.char_code, req_bus.cell_index));
         end
      end
   end

   // Drive the reply ready line at the current receiver pacing
   always @(posedge clock) rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);

   // Abort when no word moves on either channel for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles, %0d replies still due",
                  stall_cycles, due_replies.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Offer one request word and hold it until it is taken
   task automatic send_word(op_type op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
      logic idle_put;
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.char_code  <= ch;
      req_bus.cell_index <= idx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_words++;
      // Count only words that do something
      idle_put = (op == OP_PUT) && ch != CH_BACKSPACE && ch != CH_TAB &&
                 ch != CH_RETURN && ch != CH_LINE_FEED &&
                 (ch < CH_FIRST_PRINT || ch > CH_LAST_PRINT);
      if (op != OP_NOP && !idle_put) counted_items++;
   endtask

   task automatic put_byte(logic [CHAR_W-1:0] ch);
      send_word(OP_PUT, ch, IDX_W'($urandom));
   endtask

   task automatic read_cell(logic [IDX_W-1:0] idx);
      send_word(OP_READ, CHAR_W'($urandom), idx);
   endtask

   // Drop valid and wait until every reply has come back
   task automatic wait_for_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (due_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_attribute(logic [ATTR_W-1:0] value);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      attr_reg = value;
      csr_writes++;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Random text: mostly lines with random content, plus reads, noise and clears
   task automatic run_traffic(int budget);
      int goal;
      int dice;
      int pick;
      int n;
      goal = sent_words + budget;
      while (sent_words < goal) begin
         dice = $urandom_range(99);
         if (dice < 55) begin
            // short line ended by a line feed or a carriage return
            n = $urandom_range(0, 10);
            repeat (n) begin
               pick = $urandom_range(99);
               if (pick < 85)
                  put_byte(CHAR_W'($urandom_range(CH_FIRST_PRINT, CH_LAST_PRINT)));
               else if (pick < 90)
                  put_byte(CH_TAB);
               else if (pick < 95)
                  put_byte(CH_BACKSPACE);
               else
                  put_byte(CHAR_W'($urandom_range(128, 255)));
            end
            put_byte(($urandom_range(99) < 80) ? CH_LINE_FEED : CH_RETURN);
         end else if (dice < 65) begin
            // long line that can wrap past the right edge
            n = $urandom_range(25, 50);
            repeat (n) begin
               if ($urandom_range(99) < 25)
                  put_byte(CH_TAB);
               else
                  put_byte(CHAR_W'($urandom_range(CH_FIRST_PRINT, CH_LAST_PRINT)));
            end
         end else if (dice < 88) begin
            // reads, weighted to the bottom rows where text collects
            n = $urandom_range(1, 4);
            repeat (n) begin
               pick = $urandom_range(99);
               if (pick < 45)
                  read_cell(IDX_W'($urandom_range((ROWS - 5) * COLUMNS, CELL_COUNT - 1)));
               else if (pick < 90)
                  read_cell(IDX_W'($urandom_range(0, CELL_COUNT - 1)));
               else
                  read_cell(IDX_W'($urandom_range(CELL_COUNT, 2 ** IDX_W - 1)));
            end
         end else if (dice < 99) begin
            // noise: unused operation, stray control and high bytes, backspace runs
            pick = $urandom_range(3);
            if (pick == 0)
               send_word(OP_NOP, CHAR_W'($urandom), IDX_W'($urandom));
            else if (pick == 1)
               put_byte(CHAR_W'($urandom_range(0, 31)));
            else if (pick == 2)
               put_byte(CHAR_W'($urandom_range(128, 255)));
            else
               repeat ($urandom_range(1, 6)) put_byte(CH_BACKSPACE);
         end else begin
            send_word(OP_CLEAR, CHAR_W'($urandom), IDX_W'($urandom));
         end
      end
   endtask

   // Blank screen after reset, reads past the end, unused operation
   task automatic test_power_on_screen();
      read_cell('0);
      read_cell(IDX_W'(CELL_COUNT - 1));
      read_cell(IDX_W'(CELL_COUNT));
      read_cell('1);
      send_word(OP_NOP, '1, '1);
   endtask

   // Ignored bytes, printable extremes, backspace at column 0, tab, return, line feed
   task automatic test_put_byte_handling();
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte(8'h80);
      put_byte(CH_FIRST_PRINT);
      put_byte(8'h41);
      put_byte(CH_LAST_PRINT);
      repeat (4) put_byte(CH_BACKSPACE);
      put_byte(CH_TAB);
      put_byte(CH_TAB);
      put_byte(CH_RETURN);
      put_byte(8'h5A);
      put_byte(CH_LINE_FEED);
      read_cell(IDX_W'(1));
   endtask

   // Attribute extremes on stored text; clear blanks regardless of attribute
   task automatic test_attribute_extremes();
      wait_for_idle();
      set_attribute('0);
      put_byte(8'h61);
      wait_for_idle();
      set_attribute('1);
      put_byte(8'h62);
      read_cell(IDX_W'(COLUMNS));
      read_cell(IDX_W'(COLUMNS + 1));
      send_word(OP_CLEAR, '1, '1);
      read_cell(IDX_W'(COLUMNS + 1));
   endtask

   task automatic test_slow_receiver();
      wait_for_idle();
      send_idle_pct = 21;
      recv_idle_pct = 85;
      set_attribute(ATTR_W'($urandom));
      run_traffic(HALF_PHASE);
      wait_for_idle();
      set_attribute(ATTR_W'($urandom));
      run_traffic(HALF_PHASE);
   endtask

   task automatic test_slow_sender();
      wait_for_idle();
      send_idle_pct = 85;
      recv_idle_pct = 21;
      set_attribute(ATTR_W'($urandom));
      run_traffic(HALF_PHASE);
      wait_for_idle();
      set_attribute(ATTR_W'($urandom));
      run_traffic(HALF_PHASE);
   endtask

   task automatic test_full_rate();
      wait_for_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_attribute(ATTR_W'($urandom));
      run_traffic(HALF_PHASE);
      wait_for_idle();
      set_attribute(ATTR_RESET);
      run_traffic(HALF_PHASE);
   endtask

   initial begin
      reset              <= 1'b1;
      csr_write_enable   <= 1'b0;
      csr_write_data     <= ATTR_RESET;
      req_bus.valid      <= 1'b0;
      req_bus.operation  <= OP_PUT;
      req_bus.char_code  <= '0;
      req_bus.cell_index <= '0;
      attr_reg = ATTR_RESET;
      foreach (screen[i]) screen[i] = BLANK_CELL;
      cursor_col    = 0;
      cursor_row    = 0;
      send_idle_pct = 21;
      recv_idle_pct = 85;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_power_on_screen();
      test_put_byte_handling();
      test_attribute_extremes();
      test_slow_receiver();
      test_slow_sender();
      test_full_rate();
      wait_for_idle();

      $display("Sent %0d request words (%0d effective), checked %0d replies:",
               accepted_count, counted_items, reply_count);
      $display("%0d reads, %0d scrolls, %0d clears; attribute written %0d times; %0d mismatches.",
               read_count, scroll_count, clear_count, csr_writes, mismatch_count);
      if (mismatch_count == 0 && due_replies.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
